>>> rtl/suki_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package suki_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int MAX_OUT       = 64;
  localparam int KEY_W         = 64;
  localparam int KEY_TYPE_W    = 3;

  localparam logic [KEY_TYPE_W-1:0] KT_INT32     = 3'd0;
  localparam logic [KEY_TYPE_W-1:0] KT_INT64     = 3'd1;
  localparam logic [KEY_TYPE_W-1:0] KT_DATE_TIME = 3'd2;
  localparam logic [KEY_TYPE_W-1:0] KT_DOUBLE    = 3'd3;
  localparam logic [KEY_TYPE_W-1:0] KT_BOOL      = 3'd4;
  localparam logic [KEY_TYPE_W-1:0] KT_RESET     = KT_INT64;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_FINALIZE = 1'b1;

  localparam logic [1:0] ST_NEW         = 2'd0;
  localparam logic [1:0] ST_PRESENT     = 2'd1;
  localparam logic [1:0] ST_FULL        = 2'd2;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

  typedef struct packed {
    logic                    operation;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] handle;
    logic [5:0] rank;
    logic [6:0] entry_count;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [KEY_TYPE_W-1:0] key_type;
    logic [KEY_W-1:0]      target;
    logic [KEY_W-1:0]      new_key;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_INS,
    FSM_FIN,
    FSM_ONE
  } fsm_t;

  function automatic logic [KEY_W-1:0] order_key(input logic [KEY_W-1:0] bits,
                                                 input logic [KEY_TYPE_W-1:0] kt);
    logic [KEY_W-1:0] res;
    res = '0;
    case (kt)
      KT_INT32: begin
        res = {32'h0, bits[31:0] ^ 32'h8000_0000};
      end
      KT_INT64, KT_DATE_TIME: begin
        res = {~bits[KEY_W-1], bits[KEY_W-2:0]};
      end
      KT_DOUBLE: begin
        if (bits[KEY_W-2:0] == '0) begin
          res = {1'b1, {(KEY_W-1){1'b0}}};
        end else if (bits[KEY_W-1]) begin
          res = ~bits;
        end else begin
          res = {1'b1, bits[KEY_W-2:0]};
        end
      end
      default: begin
        res = {{(KEY_W-1){1'b0}}, bits[0]};
      end
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/suki_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface suki_in_if;
  import suki_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface suki_out_if;
  import suki_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/sorted_unique_key_indexer.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted dictionary of up to DEPTH distinct 64-bit keys held in a row of cells in
// ascending key order, each cell keeping one key and its stable handle. An insert
// goes through accept, one compare in every cell at once, then, once the result
// register is free, a commit that for a new key shifts the cells above the
// insertion point by one place toward the tail. A finalize rotates the row one
// cell per cycle while the sink keeps up and emits the head cell for up to
// MAX_OUT entries. Unsupported key types answer with ST_UNSUPPORTED. Program
// cfg_wdata (key type) only while the block is idle.
module sorted_unique_key_indexer #(
  parameter int DEPTH = suki_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  suki_in_if.sink                         in_ch,
  suki_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [suki_pkg::KEY_TYPE_W-1:0] cfg_wdata
);
  import suki_pkg::*;

  localparam int HW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  fsm_t                  state_r, state_nxt;
  logic [KEY_TYPE_W-1:0] key_type_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         fin_idx_r, fin_idx_nxt, fin_next;
  logic                  op_r;
  logic [KEY_W-1:0]      item_key_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  cell_ctrl_t            ctrl;
  logic [KEY_W-1:0]      cell_key [DEPTH];
  logic [HW-1:0]         cell_handle [DEPTH];
  logic                  found [DEPTH+1];
  logic [DEPTH-1:0]      first_v, eq_v;

  logic                  free, load, supported, emitting, match;
  logic [HW-1:0]         pos, match_handle;

  assign free      = !out_valid_r || out_ch.ready;
  assign supported = key_type_r <= KT_BOOL;
  assign fin_next  = fin_idx_r + CW'(1);
  assign emitting  = 32'(fin_idx_r) < MAX_OUT;
  assign found[0]  = 1'b0;

  always_comb begin
    pos          = '0;
    match_handle = '0;
    for (int p = 0; p < DEPTH; p++) begin
      if (first_v[p]) begin
        pos          = pos | HW'(p);
        match_handle = match_handle | (eq_v[p] ? cell_handle[p] : '0);
      end
    end
    match = |(first_v & eq_v);
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    fin_idx_nxt  = fin_idx_r;
    load         = 1'b0;
    out_data_nxt = out_data_r;
    ctrl.op       = CELL_HOLD;
    ctrl.key_type = key_type_r;
    ctrl.target   = order_key(item_key_r, key_type_r);
    ctrl.new_key  = item_key_r;
    in_ch.ready  = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (!supported) begin
            state_nxt = FSM_ONE;
          end else if (in_ch.data.operation == OP_FINALIZE) begin
            fin_idx_nxt = '0;
            if (count_r != '0) begin
              state_nxt = FSM_FIN;
            end
          end else begin
            state_nxt = FSM_CMP;
          end
        end
      end
      FSM_CMP: begin
        ctrl.op   = CELL_CMP;
        state_nxt = FSM_INS;
      end
      FSM_INS: begin
        if (free) begin
          load      = 1'b1;
          state_nxt = FSM_IDLE;
          out_data_nxt.last = 1'b0;
          if (match) begin
            out_data_nxt.status      = ST_PRESENT;
            out_data_nxt.handle      = 6'(match_handle);
            out_data_nxt.rank        = 6'(pos);
            out_data_nxt.entry_count = 7'(count_r);
          end else if (count_r == DEPTH_C) begin
            out_data_nxt.status      = ST_FULL;
            out_data_nxt.handle      = '0;
            out_data_nxt.rank        = '0;
            out_data_nxt.entry_count = 7'(count_r);
          end else begin
            ctrl.op                  = CELL_INS;
            count_nxt                = count_r + CW'(1);
            out_data_nxt.status      = ST_NEW;
            out_data_nxt.handle      = 6'(count_r);
            out_data_nxt.rank        = 6'(pos);
            out_data_nxt.entry_count = 7'(count_nxt);
          end
        end
      end
      FSM_FIN: begin
        if (free || !emitting) begin
          ctrl.op     = CELL_ROT;
          fin_idx_nxt = fin_next;
          if (fin_next == count_r) begin
            state_nxt = FSM_IDLE;
          end
          if (emitting) begin
            load                     = 1'b1;
            out_data_nxt.status      = ST_PRESENT;
            out_data_nxt.handle      = 6'(cell_handle[0]);
            out_data_nxt.rank        = 6'(fin_idx_r);
            out_data_nxt.entry_count = 7'(count_r);
            out_data_nxt.last        = (fin_next == count_r) ||
                                       (32'(fin_idx_r) == MAX_OUT - 1);
          end
        end
      end
      FSM_ONE: begin
        if (free) begin
          load                     = 1'b1;
          state_nxt                = FSM_IDLE;
          out_data_nxt.status      = ST_UNSUPPORTED;
          out_data_nxt.handle      = '0;
          out_data_nxt.rank        = '0;
          out_data_nxt.entry_count = 7'(count_r);
          out_data_nxt.last        = op_r;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
    out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      key_type_r  <= KT_RESET;
      count_r     <= '0;
      fin_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fin_idx_r   <= fin_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        key_type_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_ch.valid && in_ch.ready) begin
      op_r       <= in_ch.data.operation;
      item_key_r <= in_ch.data.key;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  for (genvar p = 0; p < DEPTH; p++) begin : g_cell
    logic [KEY_W-1:0] lk, rk;
    logic [HW-1:0]    lh, rh;
    if (p == 0) begin : g_head
      assign lk = cell_key[0];
      assign lh = cell_handle[0];
    end else begin : g_mid
      assign lk = cell_key[p-1];
      assign lh = cell_handle[p-1];
    end
    if (p == DEPTH - 1) begin : g_tail
      assign rk = cell_key[0];
      assign rh = cell_handle[0];
    end else begin : g_body
      assign rk = cell_key[p+1];
      assign rh = cell_handle[p+1];
    end
    suki_cell #(
      .IDX (p),
      .HW  (HW),
      .CW  (CW)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .count        (count_r),
      .new_handle   (HW'(count_r)),
      .left_key     (lk),
      .left_handle  (lh),
      .right_key    (rk),
      .right_handle (rh),
      .head_key     (cell_key[0]),
      .head_handle  (cell_handle[0]),
      .found_in     (found[p]),
      .found_out    (found[p+1]),
      .first        (first_v[p]),
      .eq           (eq_v[p]),
      .key_q        (cell_key[p]),
      .handle_q     (cell_handle[p])
    );
  end

endmodule
`default_nettype wire

>>> rtl/suki_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module suki_cell #(
  parameter int IDX = 0,
  parameter int HW  = 6,
  parameter int CW  = 7
) (
  input  logic                      clk,
  input  suki_pkg::cell_ctrl_t      ctrl,
  input  logic [CW-1:0]             count,
  input  logic [HW-1:0]             new_handle,
  input  logic [suki_pkg::KEY_W-1:0] left_key,
  input  logic [HW-1:0]             left_handle,
  input  logic [suki_pkg::KEY_W-1:0] right_key,
  input  logic [HW-1:0]             right_handle,
  input  logic [suki_pkg::KEY_W-1:0] head_key,
  input  logic [HW-1:0]             head_handle,
  input  logic                      found_in,
  output logic                      found_out,
  output logic                      first,
  output logic                      eq,
  output logic [suki_pkg::KEY_W-1:0] key_q,
  output logic [HW-1:0]             handle_q
);
  import suki_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [HW-1:0]    handle_r, handle_nxt;
  logic             hit_r, hit_nxt;
  logic             eq_r, eq_nxt;
  logic [KEY_W-1:0] cur;
  logic             valid, at_end, is_tail, ins_here;

  always_comb begin
    valid     = IDX_C < count;
    at_end    = IDX_C <= count;
    is_tail   = IDX_C == count - CW'(1);
    cur       = order_key(key_r, ctrl.key_type);
    ins_here  = !valid || hit_r;
    first     = ins_here && !found_in;
    found_out = found_in || ins_here;
    eq        = eq_r;
    key_q     = key_r;
    handle_q  = handle_r;
  end

  always_comb begin
    key_nxt    = key_r;
    handle_nxt = handle_r;
    hit_nxt    = hit_r;
    eq_nxt     = eq_r;
    case (ctrl.op)
      CELL_CMP: begin
        hit_nxt = cur >= ctrl.target;
        eq_nxt  = valid && (cur == ctrl.target);
      end
      CELL_INS: begin
        if (first) begin
          key_nxt    = ctrl.new_key;
          handle_nxt = new_handle;
        end else if (found_in && at_end) begin
          key_nxt    = left_key;
          handle_nxt = left_handle;
        end
      end
      CELL_ROT: begin
        if (valid) begin
          if (is_tail) begin
            key_nxt    = head_key;
            handle_nxt = head_handle;
          end else begin
            key_nxt    = right_key;
            handle_nxt = right_handle;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
    hit_r    <= hit_nxt;
    eq_r     <= eq_nxt;
  end

endmodule
`default_nettype wire

>>> verif/tb_sorted_unique_key_indexer.sv
`timescale 1ns / 1ps
module tb_sorted_unique_key_indexer;
  import suki_pkg::*;

  localparam int TABLE_SLOTS = 64;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [KEY_TYPE_W-1:0] KT_UNSUP_FIRST = 3'd5;
  localparam logic [KEY_TYPE_W-1:0] KT_UNSUP_LAST = 3'd7;
  localparam logic [63:0] KEY_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DBL_POS_INF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DBL_NEG_INF = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] DBL_POS_NAN = 64'h7FF8_0000_0000_0001;
  localparam logic [63:0] DBL_NEG_NAN = 64'hFFF8_0000_0000_0001;
  localparam logic [63:0] DBL_ONE = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] BOUNDARY_KEYS [12] = '{
    KEY_MIN, KEY_MAX, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, DBL_POS_INF, DBL_NEG_INF,
    DBL_POS_NAN, DBL_NEG_NAN, DBL_ONE, 64'hBFF0_0000_0000_0000,
    64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000
  };

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_CHOKE
  } rx_mode_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [KEY_TYPE_W-1:0] cfg_wdata;

  suki_in_if in_ch ();
  suki_out_if out_ch ();

  sorted_unique_key_indexer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  in_item_t queued_requests[$];
  out_item_t awaited_lookups[$];
  logic [63:0] key_history[$];

  logic [63:0] stored_keys [TABLE_SLOTS];
  logic [5:0] sorted_slots [TABLE_SLOTS];
  int stored_total;
  logic [KEY_TYPE_W-1:0] key_kind;

  int sent_count = 0;
  int accepted_count = 0;
  int error_count = 0;
  bit in_taken = 0;
  int burst_left = 1;
  int gap_left = 0;
  rx_mode_t rx_mode = RX_STREAM;
  int rx_mode_left = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] sort_value(input logic [63:0] bits,
                                             input logic [KEY_TYPE_W-1:0] kind);
    case (kind)
      KT_INT32: begin
        return {32'h0, ~bits[31], bits[30:0]};
      end
      KT_INT64, KT_DATE_TIME: begin
        return bits ^ KEY_MIN;
      end
      KT_DOUBLE: begin
        if (bits[62:0] == 63'h0) begin
          return KEY_MIN;
        end else if (bits[63]) begin
          return ~bits;
        end
        return bits | KEY_MIN;
      end
      default: begin
        return {63'h0, bits[0]};
      end
    endcase
  endfunction

  task automatic await_lookup(input logic [1:0] status, input logic [5:0] handle,
                              input logic [5:0] rank, input logic last);
    out_item_t r;
    r.status = status;
    r.handle = handle;
    r.rank = rank;
    r.entry_count = stored_total[6:0];
    r.last = last;
    awaited_lookups.push_back(r);
  endtask

  task automatic index_request(input in_item_t req);
    logic [63:0] target;
    logic [63:0] cur;
    int pos;
    int i;
    if (key_kind > KT_BOOL) begin
      await_lookup(ST_UNSUPPORTED, 6'd0, 6'd0, req.operation == OP_FINALIZE);
      return;
    end
    if (req.operation == OP_FINALIZE) begin
      for (i = 0; i < stored_total; i++) begin
        await_lookup(ST_PRESENT, sorted_slots[i], i[5:0], i == stored_total - 1);
      end
      return;
    end
    target = sort_value(req.key, key_kind);
    for (pos = 0; pos < stored_total; pos++) begin
      cur = sort_value(stored_keys[sorted_slots[pos]], key_kind);
      if (cur == target) begin
        await_lookup(ST_PRESENT, sorted_slots[pos], pos[5:0], 1'b0);
        return;
      end
      if (cur > target) begin
        break;
      end
    end
    if (stored_total >= TABLE_SLOTS) begin
      await_lookup(ST_FULL, 6'd0, 6'd0, 1'b0);
      return;
    end
    for (i = stored_total; i > pos; i--) begin
      sorted_slots[i] = sorted_slots[i-1];
    end
    stored_keys[stored_total] = req.key;
    sorted_slots[pos] = stored_total[5:0];
    stored_total++;
    await_lookup(ST_NEW, sorted_slots[pos], pos[5:0], 1'b0);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic compare_lookup(input out_item_t got);
    out_item_t want;
    if (awaited_lookups.size() == 0) begin
      $error("unexpected result: status %0d handle %0d rank %0d", got.status,
             got.handle, got.rank);
      error_count++;
      return;
    end
    want = awaited_lookups.pop_front();
    check_field("status", want.status, got.status);
    check_field("handle", want.handle, got.handle);
    check_field("rank", want.rank, got.rank);
    check_field("entry_count", want.entry_count, got.entry_count);
    check_field("last", want.last, got.last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stored_total = 0;
      key_kind = KT_RESET;
    end else begin
      if (cfg_we) begin
        key_kind = cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        index_request(in_ch.data);
        accepted_count++;
        in_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        compare_lookup(out_ch.data);
      end
    end
  end

  always @(negedge clk) begin
    logic next_valid;
    in_item_t next_data;
    next_valid = in_ch.valid;
    next_data = in_ch.data;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!(in_ch.valid && !in_taken)) begin
      in_taken = 1'b0;
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (queued_requests.size() > 0) begin
        next_data = queued_requests.pop_front();
        next_valid = 1'b1;
        sent_count++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_ch.valid <= next_valid;
    in_ch.data <= next_data;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(10, 60);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_STREAM: begin
          out_ch.ready <= 1'b1;
        end
        RX_COIN: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  function automatic logic [63:0] random_key();
    int unsigned sel;
    int s;
    sel = $urandom_range(0, 99);
    if (sel < 25 && key_history.size() > 0) begin
      return key_history[$urandom_range(0, key_history.size() - 1)];
    end
    if (sel < 40) begin
      return BOUNDARY_KEYS[$urandom_range(0, 11)];
    end
    if (sel < 55) begin
      s = int'($urandom_range(0, 31)) - 16;
      return {{32{s[31]}}, s};
    end
    if (sel < 70) begin
      return {$urandom, 28'h0, 4'($urandom_range(0, 15))};
    end
    return {$urandom, $urandom};
  endfunction

  task automatic queue_request(input logic op, input logic [63:0] key);
    in_item_t req;
    req.operation = op;
    req.key = key;
    queued_requests.push_back(req);
    if (op == OP_INSERT) begin
      key_history.push_back(key);
    end
  endtask

  task automatic settle();
    while (queued_requests.size() != 0 || sent_count != accepted_count ||
           awaited_lookups.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_key_type(input logic [KEY_TYPE_W-1:0] kind);
    settle();
    @(negedge clk);
    cfg_wdata <= kind;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input logic [KEY_TYPE_W-1:0] kind, input int count);
    set_key_type(kind);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_request(OP_FINALIZE, {$urandom, $urandom});
      end else begin
        queue_request(OP_INSERT, random_key());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_request(OP_FINALIZE, 64'h0);

    set_key_type(KT_INT64);
    queue_request(OP_INSERT, KEY_MIN);
    queue_request(OP_INSERT, KEY_MAX);
    queue_request(OP_INSERT, 64'h0);
    queue_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_request(OP_INSERT, 64'h0);
    queue_request(OP_INSERT, 64'h1);
    queue_request(OP_FINALIZE, 64'hFFFF_FFFF_FFFF_FFFF);

    set_key_type(KT_DOUBLE);
    queue_request(OP_INSERT, KEY_MIN);
    queue_request(OP_INSERT, DBL_POS_INF);
    queue_request(OP_INSERT, DBL_NEG_INF);
    queue_request(OP_INSERT, DBL_POS_NAN);
    queue_request(OP_INSERT, DBL_NEG_NAN);
    queue_request(OP_INSERT, DBL_ONE);
    queue_request(OP_FINALIZE, 64'h0);

    set_key_type(KT_INT32);
    queue_request(OP_INSERT, 64'h0000_0001_8000_0000);
    queue_request(OP_INSERT, 64'hFFFF_FFFF_7FFF_FFFF);

    set_key_type(KT_BOOL);
    queue_request(OP_INSERT, 64'h2);
    queue_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);

    set_key_type(KT_DATE_TIME);
    queue_request(OP_INSERT, 64'h0000_0000_0000_0010);

    set_key_type(KT_UNSUP_FIRST);
    queue_request(OP_INSERT, 64'h5);
    queue_request(OP_FINALIZE, 64'h0);

    set_key_type(KT_UNSUP_LAST);
    queue_request(OP_INSERT, 64'h7);

    run_random_phase(KT_INT64, 30);
    run_random_phase(KT_DOUBLE, 16);
    run_random_phase(KT_DATE_TIME, 10);
    run_random_phase(KT_INT32, 10);
    run_random_phase(3'($urandom_range(KT_UNSUP_FIRST, KT_UNSUP_LAST)), 4);
    run_random_phase(KT_BOOL, 6);
    run_random_phase(KT_INT64, 10);

    settle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
